>>> src/stochastic_vol_rate_path_step_core_assert.svh
// Assertion macros for the stochastic volatility path step core.
`ifndef STOCHASTIC_VOL_RATE_PATH_STEP_CORE_ASSERT_SVH
`define STOCHASTIC_VOL_RATE_PATH_STEP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define SVRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SVRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/svrps_pkg.sv
// Types, constants and the step microcode for the stochastic volatility path step core.
package svrps_pkg;

    localparam int PATH_STEPS = 100;
    localparam int IDX_W      = 12;
    localparam int PC_W       = 6;
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(36);

    localparam logic signed [31:0] FX_ONE  = 32'sd1048576;
    localparam logic signed [31:0] FX_DT   = 32'sd10486;
    localparam logic signed [31:0] FX_SQDT = 32'sd104858;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        CFG_KAPPA = 3'd0,
        CFG_THETA = 3'd1,
        CFG_LAMBDA = 3'd2,
        CFG_NU    = 3'd3,
        CFG_ETA   = 3'd4,
        CFG_ALPHA = 3'd5,
        CFG_RSV   = 3'd6,
        CFG_RSR   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_MUL  = 2'd0,
        K_SQRT = 2'd1,
        K_ADD  = 2'd2,
        K_SUB  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5, SRC_T6, SRC_T7,
        SRC_ZERO, SRC_ONE, SRC_DT, SRC_SQDT,
        SRC_ZS, SRC_ZV, SRC_ZR,
        SRC_R, SRC_S, SRC_A, SRC_CUM,
        SRC_KAP, SRC_THET, SRC_LAM, SRC_NU, SRC_ETA, SRC_ALP, SRC_RSV, SRC_RSR
    } t_src;

    typedef struct packed {
        t_kind      kind;
        t_src       a;
        t_src       b;
        logic       add_t3;   // three-term add, third term is T3
        logic [2:0] dst;
    } t_uop;

    function automatic t_uop mk(t_kind k, t_src a, t_src b, logic c, logic [2:0] d);
        t_uop u;
        u.kind   = k;
        u.a      = a;
        u.b      = b;
        u.add_t3 = c;
        u.dst    = d;
        return u;
    endfunction

    function automatic logic signed [31:0] sat48(logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'(S32_MAX)) r = S32_MAX;
        else if (v < 48'(S32_MIN)) r = S32_MIN;
        else r = v[31:0];
        return r;
    endfunction

    // One Euler step: rate, then volatility, then asset, then running sum.
    function automatic t_uop ucode(logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(K_MUL,  SRC_ZS,   SRC_SQDT, 1'b0, 3'd0);
            6'd1:  u = mk(K_MUL,  SRC_RSR,  SRC_RSR,  1'b0, 3'd1);
            6'd2:  u = mk(K_SUB,  SRC_ONE,  SRC_T1,   1'b0, 3'd1);
            6'd3:  u = mk(K_SQRT, SRC_T1,   SRC_ZERO, 1'b0, 3'd1);
            6'd4:  u = mk(K_MUL,  SRC_ZR,   SRC_SQDT, 1'b0, 3'd2);
            6'd5:  u = mk(K_MUL,  SRC_T1,   SRC_T2,   1'b0, 3'd2);
            6'd6:  u = mk(K_MUL,  SRC_RSR,  SRC_T0,   1'b0, 3'd1);
            6'd7:  u = mk(K_ADD,  SRC_T1,   SRC_T2,   1'b0, 3'd1);
            6'd8:  u = mk(K_MUL,  SRC_ETA,  SRC_R,    1'b0, 3'd2);
            6'd9:  u = mk(K_SUB,  SRC_NU,   SRC_T2,   1'b0, 3'd2);
            6'd10: u = mk(K_MUL,  SRC_T2,   SRC_DT,   1'b0, 3'd2);
            6'd11: u = mk(K_MUL,  SRC_ALP,  SRC_R,    1'b0, 3'd3);
            6'd12: u = mk(K_SQRT, SRC_T3,   SRC_ZERO, 1'b0, 3'd3);
            6'd13: u = mk(K_MUL,  SRC_T3,   SRC_T1,   1'b0, 3'd3);
            6'd14: u = mk(K_ADD,  SRC_R,    SRC_T2,   1'b1, 3'd4);
            6'd15: u = mk(K_MUL,  SRC_RSV,  SRC_RSV,  1'b0, 3'd1);
            6'd16: u = mk(K_SUB,  SRC_ONE,  SRC_T1,   1'b0, 3'd1);
            6'd17: u = mk(K_SQRT, SRC_T1,   SRC_ZERO, 1'b0, 3'd1);
            6'd18: u = mk(K_MUL,  SRC_ZV,   SRC_SQDT, 1'b0, 3'd2);
            6'd19: u = mk(K_MUL,  SRC_T1,   SRC_T2,   1'b0, 3'd2);
            6'd20: u = mk(K_MUL,  SRC_RSV,  SRC_T0,   1'b0, 3'd1);
            6'd21: u = mk(K_ADD,  SRC_T1,   SRC_T2,   1'b0, 3'd1);
            6'd22: u = mk(K_SUB,  SRC_THET, SRC_S,    1'b0, 3'd2);
            6'd23: u = mk(K_MUL,  SRC_KAP,  SRC_T2,   1'b0, 3'd2);
            6'd24: u = mk(K_MUL,  SRC_T2,   SRC_DT,   1'b0, 3'd2);
            6'd25: u = mk(K_SQRT, SRC_S,    SRC_ZERO, 1'b0, 3'd3);
            6'd26: u = mk(K_MUL,  SRC_LAM,  SRC_T3,   1'b0, 3'd3);
            6'd27: u = mk(K_MUL,  SRC_T3,   SRC_T1,   1'b0, 3'd3);
            6'd28: u = mk(K_ADD,  SRC_S,    SRC_T2,   1'b1, 3'd5);
            6'd29: u = mk(K_MUL,  SRC_R,    SRC_DT,   1'b0, 3'd1);
            6'd30: u = mk(K_MUL,  SRC_S,    SRC_DT,   1'b0, 3'd2);
            6'd31: u = mk(K_SQRT, SRC_T2,   SRC_ZERO, 1'b0, 3'd2);
            6'd32: u = mk(K_MUL,  SRC_T2,   SRC_ZS,   1'b0, 3'd2);
            6'd33: u = mk(K_ADD,  SRC_T1,   SRC_T2,   1'b0, 3'd1);
            6'd34: u = mk(K_MUL,  SRC_A,    SRC_T1,   1'b0, 3'd1);
            6'd35: u = mk(K_ADD,  SRC_A,    SRC_T1,   1'b0, 3'd6);
            6'd36: u = mk(K_ADD,  SRC_CUM,  SRC_T4,   1'b0, 3'd7);
            default: u = mk(K_ADD, SRC_ZERO, SRC_ZERO, 1'b0, 3'd0);
        endcase
        return u;
    endfunction

endpackage

>>> src/stochastic_vol_rate_path_step_core.sv
// Euler step of a correlated asset / volatility / short-rate path, microcoded.
//
// Input stream (s_axis): tuser = start_path. A start transaction loads the
// initial asset, volatility and rate; any other transaction applies three
// Q4.12 normal draws and advances the stored state one time step.
// Output stream (m_axis): one transaction per input, carrying the state after
// it, the running rate sum and the step index; tlast marks the final step.
// Config: i_cfg_we writes i_cfg_wdata into register i_cfg_idx at once.
// A start goes from acceptance straight to the output state, which commits it.
// An advance runs a 37-entry microprogram on one radix-16 serial multiplier
// (21 products) and one bit-pair serial square root (5 roots) plus 11 adds
// done in the issue state. One item is in flight at a time; s_axis_tready
// rises again once the result sits in the output register, so the next item
// is accepted while that result waits.
// If m_axis_tready is low, the next result holds at its commit step until the
// output register frees up. Reset clears state, step count and valid flags
// and restores the register defaults; no clearing pass is needed.
module stochastic_vol_rate_path_step_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // init_asset, init_vol, init_rate, shock_asset, shock_vol, shock_rate
    input  logic [143:0]   s_axis_tdata,
    // start_path
    input  logic           s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // asset_out, vol_out, rate_out, cum_rate_out, step_index, zero pad
    output logic [143:0]   m_axis_tdata,
    // last_step
    output logic           m_axis_tlast,
    input  logic           i_cfg_we,
    input  svrps_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]    i_cfg_wdata
);
    import svrps_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_MUL, ST_SQRT, ST_OUT} t_state;

    t_state r_state;
    logic [PC_W-1:0] r_pc;
    logic r_start;

    logic [30:0] r_kap, r_thet, r_lam, r_alp;
    logic signed [31:0] r_nu, r_eta;
    logic signed [21:0] r_rsv, r_rsr;

    logic signed [31:0] r_a, r_s, r_r, r_cum;
    logic [IDX_W-1:0] r_cnt;

    logic signed [31:0] r_in_a, r_in_s, r_in_r;
    logic signed [15:0] r_zs, r_zv, r_zr;

    logic signed [31:0] r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;

    logic signed [31:0] r_ma, r_mb;
    logic signed [67:0] r_mp;
    logic [2:0] r_mcnt;

    logic [51:0] r_sn;
    logic [27:0] r_srem;
    logic [25:0] r_sroot;
    logic [4:0]  r_scnt;

    logic r_ovalid, r_olast;
    logic signed [31:0] r_oa, r_os, r_or, r_ocum;
    logic [IDX_W-1:0] r_oidx;

    t_uop w_u;
    logic signed [31:0] w_opa, w_opb, w_res_alu, w_res_mul;
    logic signed [4:0]  w_dig;
    logic signed [36:0] w_pp;
    logic signed [67:0] w_mp_nxt;
    logic [29:0] w_rem2, w_trial;
    logic w_ge;
    logic [IDX_W-1:0] w_cnt_nxt;
    logic w_out_free;

    function automatic logic signed [31:0] scale_z(logic signed [15:0] z);
        return {{8{z[15]}}, z, 8'd0};
    endfunction

    function automatic logic signed [31:0] pick(t_src s);
        logic signed [31:0] v;
        case (s)
            SRC_T0:   v = r_t0;
            SRC_T1:   v = r_t1;
            SRC_T2:   v = r_t2;
            SRC_T3:   v = r_t3;
            SRC_T4:   v = r_t4;
            SRC_T5:   v = r_t5;
            SRC_T6:   v = r_t6;
            SRC_T7:   v = r_t7;
            SRC_ONE:  v = FX_ONE;
            SRC_DT:   v = FX_DT;
            SRC_SQDT: v = FX_SQDT;
            SRC_ZS:   v = scale_z(r_zs);
            SRC_ZV:   v = scale_z(r_zv);
            SRC_ZR:   v = scale_z(r_zr);
            SRC_R:    v = r_r;
            SRC_S:    v = r_s;
            SRC_A:    v = r_a;
            SRC_CUM:  v = r_cum;
            SRC_KAP:  v = {1'b0, r_kap};
            SRC_THET: v = {1'b0, r_thet};
            SRC_LAM:  v = {1'b0, r_lam};
            SRC_NU:   v = r_nu;
            SRC_ETA:  v = r_eta;
            SRC_ALP:  v = {1'b0, r_alp};
            SRC_RSV:  v = 32'(r_rsv);
            SRC_RSR:  v = 32'(r_rsr);
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_u   = ucode(r_pc);
        w_opa = pick(w_u.a);
        w_opb = pick(w_u.b);
        if (w_u.kind == K_SUB) begin
            w_res_alu = sat48(48'(w_opa) - 48'(w_opb));
        end else begin
            w_res_alu = sat48(48'(w_opa) + 48'(w_opb) + (w_u.add_t3 ? 48'(r_t3) : 48'sd0));
        end
        // top digit of the multiplier is signed
        w_dig     = (r_mcnt == 3'd7) ? {r_mb[3], r_mb[3:0]} : {1'b0, r_mb[3:0]};
        w_pp      = r_ma * w_dig;
        w_mp_nxt  = (r_mp >>> 4) + (68'(w_pp) <<< 32);
        // product is w_mp_nxt / 16; result is floor(product / 2^20)
        w_res_mul = sat48(48'($signed(w_mp_nxt[67:24])));
        w_rem2    = {r_srem, r_sn[51:50]};
        w_trial   = {2'b00, r_sroot, 2'b01};
        w_ge      = (w_rem2 >= w_trial);
        w_cnt_nxt = (r_cnt < IDX_W'(PATH_STEPS - 1)) ? r_cnt + 1'b1 : r_cnt;
        w_out_free = !r_ovalid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kap  <= 31'd104858;
            r_thet <= 31'd104858;
            r_lam  <= 31'd104858;
            r_nu   <= 32'sd104858;
            r_eta  <= 32'sd104858;
            r_alp  <= 31'd20972;
            r_rsv  <= 22'sd104858;
            r_rsr  <= 22'sd104858;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KAPPA:  r_kap  <= i_cfg_wdata[30:0];
                CFG_THETA:  r_thet <= i_cfg_wdata[30:0];
                CFG_LAMBDA: r_lam  <= i_cfg_wdata[30:0];
                CFG_NU:     r_nu   <= i_cfg_wdata;
                CFG_ETA:    r_eta  <= i_cfg_wdata;
                CFG_ALPHA:  r_alp  <= i_cfg_wdata[30:0];
                CFG_RSV:    r_rsv  <= i_cfg_wdata[21:0];
                CFG_RSR:    r_rsr  <= i_cfg_wdata[21:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_start  <= 1'b0;
            r_a      <= '0;
            r_s      <= '0;
            r_r      <= '0;
            r_cum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_mcnt   <= '0;
            r_scnt   <= '0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != ST_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_start <= s_axis_tuser;
                        r_in_a  <= s_axis_tdata[31:0];
                        r_in_s  <= s_axis_tdata[63:32];
                        r_in_r  <= s_axis_tdata[95:64];
                        r_zs    <= s_axis_tdata[111:96];
                        r_zv    <= s_axis_tdata[127:112];
                        r_zr    <= s_axis_tdata[143:128];
                        r_pc    <= '0;
                        r_state <= s_axis_tuser ? ST_OUT : ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    unique case (w_u.kind)
                        K_MUL: begin
                            r_ma    <= w_opa;
                            r_mb    <= w_opb;
                            r_mp    <= '0;
                            r_mcnt  <= '0;
                            r_state <= ST_MUL;
                        end
                        K_SQRT: begin
                            r_sn    <= (w_opa > 32'sd0) ? {1'b0, w_opa[30:0], 20'd0} : '0;
                            r_srem  <= '0;
                            r_sroot <= '0;
                            r_scnt  <= '0;
                            r_state <= ST_SQRT;
                        end
                        K_ADD, K_SUB: begin
                            case (w_u.dst)
                                3'd0: r_t0 <= w_res_alu;
                                3'd1: r_t1 <= w_res_alu;
                                3'd2: r_t2 <= w_res_alu;
                                3'd3: r_t3 <= w_res_alu;
                                3'd4: r_t4 <= w_res_alu;
                                3'd5: r_t5 <= w_res_alu;
                                3'd6: r_t6 <= w_res_alu;
                                default: r_t7 <= w_res_alu;
                            endcase
                            r_pc    <= r_pc + 1'b1;
                            r_state <= (r_pc == PC_LAST) ? ST_OUT : ST_ISSUE;
                        end
                    endcase
                end
                ST_MUL: begin
                    r_mp   <= w_mp_nxt;
                    r_mb   <= r_mb >>> 4;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 3'd7) begin
                        case (w_u.dst)
                            3'd0: r_t0 <= w_res_mul;
                            3'd1: r_t1 <= w_res_mul;
                            3'd2: r_t2 <= w_res_mul;
                            3'd3: r_t3 <= w_res_mul;
                            3'd4: r_t4 <= w_res_mul;
                            3'd5: r_t5 <= w_res_mul;
                            3'd6: r_t6 <= w_res_mul;
                            default: r_t7 <= w_res_mul;
                        endcase
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_SQRT: begin
                    r_sn   <= {r_sn[49:0], 2'b00};
                    r_scnt <= r_scnt + 1'b1;
                    if (w_ge) begin
                        r_srem  <= 28'(w_rem2 - w_trial);
                        r_sroot <= {r_sroot[24:0], 1'b1};
                    end else begin
                        r_srem  <= w_rem2[27:0];
                        r_sroot <= {r_sroot[24:0], 1'b0};
                    end
                    if (r_scnt == 5'd25) begin
                        case (w_u.dst)
                            3'd0: r_t0 <= {6'd0, r_sroot[24:0], w_ge};
                            3'd1: r_t1 <= {6'd0, r_sroot[24:0], w_ge};
                            3'd2: r_t2 <= {6'd0, r_sroot[24:0], w_ge};
                            3'd3: r_t3 <= {6'd0, r_sroot[24:0], w_ge};
                            default: r_t4 <= {6'd0, r_sroot[24:0], w_ge};
                        endcase
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        if (r_start) begin
                            r_a <= r_in_a; r_s <= r_in_s; r_r <= r_in_r; r_cum <= r_in_r;
                            r_cnt <= '0;
                            r_oa <= r_in_a; r_os <= r_in_s; r_or <= r_in_r; r_ocum <= r_in_r;
                            r_oidx  <= '0;
                            r_olast <= (IDX_W'(PATH_STEPS - 1) == '0);
                        end else begin
                            r_a <= r_t6; r_s <= r_t5; r_r <= r_t4; r_cum <= r_t7;
                            r_cnt <= w_cnt_nxt;
                            r_oa <= r_t6; r_os <= r_t5; r_or <= r_t4; r_ocum <= r_t7;
                            r_oidx  <= w_cnt_nxt;
                            r_olast <= (w_cnt_nxt == IDX_W'(PATH_STEPS - 1));
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {4'd0, r_oidx, r_ocum, r_or, r_os, r_oa};

`include "stochastic_vol_rate_path_step_core_assert.svh"

    `SVRP_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "second transaction accepted while one is in flight")
    `SVRP_ASSERT_IMP(a_pc_range, r_state == ST_ISSUE, r_pc <= PC_LAST,
        "microprogram counter past end")
    `SVRP_ASSERT_IMP(a_last_flag, m_axis_tvalid,
        m_axis_tlast == (r_oidx == IDX_W'(PATH_STEPS - 1)), "last flag disagrees with index")
    `SVRP_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= IDX_W'(PATH_STEPS - 1),
        "step count beyond path end")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the stochastic volatility / short-rate path step core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import svrps_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        bit                 start;
        logic signed [31:0] ia, iv, ir;
        logic signed [15:0] zs, zv, zr;
    } t_path_item;

    typedef struct {
        longint asset, vol, rate, cum;
        int     idx;
        bit     last;
    } t_path_state;

    // Holds the step predictor, its register copy and the queue of predicted states.
    class t_path_step_scoreboard;
        longint kap, thet, lam, nu, eta, alp, rsv, rsr;
        longint asset, vol, rate, cum;
        int steps;
        t_path_state predicted_q[$];
        int errors, checked;

        function new();
            kap = 104858; thet = 104858; lam = 104858;
            nu = 104858; eta = 104858; alp = 20972;
            rsv = 104858; rsr = 104858;
            asset = 0; vol = 0; rate = 0; cum = 0; steps = 0;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_KAPPA:  kap  = longint'(v[30:0]);
                CFG_THETA:  thet = longint'(v[30:0]);
                CFG_LAMBDA: lam  = longint'(v[30:0]);
                CFG_NU:     nu   = longint'($signed(v));
                CFG_ETA:    eta  = longint'($signed(v));
                CFG_ALPHA:  alp  = longint'(v[30:0]);
                CFG_RSV:    rsv  = longint'($signed(v[21:0]));
                CFG_RSR:    rsr  = longint'($signed(v[21:0]));
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint mulq(longint a, longint b);
            return sat((a * b) >>> 20);
        endfunction

        // floor(sqrt(x * 2^20)), zero for non-positive arguments
        function longint sqrtq(longint x);
            longint unsigned n, res, bitv;
            if (x <= 0) return 0;
            n = longint'(x) << 20;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function void note_input(t_path_item it);
            longint one, dt, sqdt, zs, zv, zr, dws, cr, cv, inner, nr, ns, ret, na;
            t_path_state p;
            one = longint'(FX_ONE); dt = longint'(FX_DT); sqdt = longint'(FX_SQDT);
            if (it.start) begin
                asset = longint'(it.ia); vol = longint'(it.iv); rate = longint'(it.ir);
                cum = rate; steps = 0;
            end else begin
                zs = longint'(it.zs) * 256;
                zv = longint'(it.zv) * 256;
                zr = longint'(it.zr) * 256;
                dws = mulq(zs, sqdt);
                cr = sqrtq(one - mulq(rsr, rsr));
                inner = sat(mulq(rsr, dws) + mulq(cr, mulq(zr, sqdt)));
                nr = sat(rate + mulq(sat(nu - mulq(eta, rate)), dt)
                         + mulq(sqrtq(mulq(alp, rate)), inner));
                cv = sqrtq(one - mulq(rsv, rsv));
                inner = sat(mulq(rsv, dws) + mulq(cv, mulq(zv, sqdt)));
                ns = sat(vol + mulq(mulq(kap, sat(thet - vol)), dt)
                         + mulq(mulq(lam, sqrtq(vol)), inner));
                ret = sat(mulq(rate, dt) + mulq(sqrtq(mulq(vol, dt)), zs));
                na = sat(asset + mulq(asset, ret));
                asset = na; vol = ns; rate = nr;
                cum = sat(cum + nr);
                if (steps < PATH_STEPS - 1) steps++;
            end
            p.asset = asset; p.vol = vol; p.rate = rate; p.cum = cum;
            p.idx = steps; p.last = (steps == PATH_STEPS - 1);
            predicted_q.push_back(p);
        endfunction

        task report_mismatch(string field, longint got, longint want);
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     checked, field, got, want);
            errors++;
        endtask

        task check_result(logic [143:0] d, logic last);
            t_path_state p;
            if (predicted_q.size() == 0) begin
                $display("result with no transaction pending");
                errors++;
                return;
            end
            p = predicted_q.pop_front();
            if (longint'($signed(d[31:0])) != p.asset)
                report_mismatch("asset", longint'($signed(d[31:0])), p.asset);
            if (longint'($signed(d[63:32])) != p.vol)
                report_mismatch("vol", longint'($signed(d[63:32])), p.vol);
            if (longint'($signed(d[95:64])) != p.rate)
                report_mismatch("rate", longint'($signed(d[95:64])), p.rate);
            if (longint'($signed(d[127:96])) != p.cum)
                report_mismatch("cum_rate", longint'($signed(d[127:96])), p.cum);
            if (int'(d[139:128]) != p.idx)
                report_mismatch("step_index", longint'(d[139:128]), p.idx);
            if (last != p.last)
                report_mismatch("last_step", longint'(last), longint'(p.last));
            checked++;
        endtask
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    // init_asset, init_vol, init_rate, shock_asset, shock_vol, shock_rate
    logic [143:0]   s_axis_tdata = '0;
    // start_path
    logic           s_axis_tuser = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // asset_out, vol_out, rate_out, cum_rate_out, step_index, zero pad
    logic [143:0]   m_axis_tdata;
    logic           m_axis_tlast;
    logic           i_cfg_we = 1'b0;
    t_cfg_idx       i_cfg_idx = CFG_KAPPA;
    logic [31:0]    i_cfg_wdata = '0;

    stochastic_vol_rate_path_step_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_path_step_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_cnt = 0;
    int  cycles = 0;
    int  n_items = 0, n_starts = 0;

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 800;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // transaction monitor: results are checked before the same-edge input is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready) begin
                t_path_item it;
                it.start = s_axis_tuser;
                {it.zr, it.zv, it.zs, it.ir, it.iv, it.ia} = s_axis_tdata;
                sb.note_input(it);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout, %0d results still pending", sb.predicted_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(t_path_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.start;
        s_axis_tdata <= {it.zr, it.zv, it.zs, it.ir, it.iv, it.ia};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
        if (it.start) n_starts++;
    endtask

    // shock arguments are taken 32 bits wide; the low 16 bits are sent
    task automatic send_fields(bit st, logic [31:0] ia, logic [31:0] iv, logic [31:0] ir,
                               logic [31:0] zs, logic [31:0] zv, logic [31:0] zr);
        t_path_item it;
        it.start = st; it.ia = ia; it.iv = iv; it.ir = ir;
        it.zs = zs[15:0]; it.zv = zv[15:0]; it.zr = zr[15:0];
        send_item(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.predicted_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic program_regs(logic [31:0] kap, logic [31:0] thet, logic [31:0] lam,
                                logic [31:0] nu, logic [31:0] eta, logic [31:0] alp,
                                logic [31:0] rsv, logic [31:0] rsr);
        write_reg(CFG_KAPPA, kap);
        write_reg(CFG_THETA, thet);
        write_reg(CFG_LAMBDA, lam);
        write_reg(CFG_NU, nu);
        write_reg(CFG_ETA, eta);
        write_reg(CFG_ALPHA, alp);
        write_reg(CFG_RSV, rsv);
        write_reg(CFG_RSR, rsr);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_corr();
        return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endfunction

    task automatic program_random();
        program_regs($urandom_range(0, 4 << 20), $urandom_range(0, 1 << 19),
                     $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 16),
                     32'($signed($urandom_range(0, 2 << 20)) - (1 << 20)),
                     $urandom_range(0, 1 << 17), rand_corr(), rand_corr());
    endtask

    function automatic logic [15:0] normal_draw();
        return 16'($signed($urandom_range(0, 16384)) - 8192);
    endfunction

    // mostly well-formed paths with plausible values, some fully random noise
    task automatic run_paths(int n);
        int sent, len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                send_fields(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
                sent++;
            end else begin
                send_fields(1'b1, $urandom_range(1, 100) << 20, $urandom_range(0, 1 << 20),
                            $urandom_range(0, 1 << 17), $urandom(), $urandom(), $urandom());
                len = ($urandom_range(7) == 0) ? $urandom_range(95, 110) : $urandom_range(1, 30);
                repeat (len) send_fields(1'b0, $urandom(), $urandom(), $urandom(),
                                         normal_draw(), normal_draw(), normal_draw());
                sent += len + 1;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers
        send_fields(1'b0, 0, 0, 0, 16'sd4096, 16'sd4096, 16'sd4096);  // advance before start
        send_fields(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_fields(1'b0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_fields(1'b0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
        send_fields(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
        send_fields(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'h0000);
        send_fields(1'b0, 0, 0, 0, 16'h7FFF, 16'h8000, 16'hFFFF);
        // negative vol and rate: square roots clamp to zero
        send_fields(1'b1, 32'd1 << 20, -32'sd100000, -32'sd50000, 0, 0, 0);
        send_fields(1'b0, 0, 0, 0, 16'sd2000, -16'sd3000, 16'sd1000);
        send_fields(1'b0, 0, 0, 0, -16'sd8000, 16'sd8000, -16'sd8000);
        send_fields(1'b1, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(1'b0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(1'b1, 32'd5 << 20, 32'd209715, 32'd52429, 0, 0, 0);
        repeat (8) send_fields(1'b0, $urandom(), $urandom(), $urandom(),
                               normal_draw(), normal_draw(), normal_draw());
        drain();

        send_idle_pct = 67; recv_stall_pct = 0;
        program_random();
        run_paths(250);
        drain();

        send_idle_pct = 0; recv_stall_pct = 67;
        program_random();
        run_paths(250);
        drain();

        // top of every register range but rate correlation (set to one); vol correlation beyond one
        send_idle_pct = 10; recv_stall_pct = 10;
        program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h001F_FFFF, 32'h0010_0000);
        run_paths(150);
        drain();

        // bottom of every register range but vol correlation (minus one), long output hold-off
        send_idle_pct = 0; recv_stall_pct = 0;
        program_regs(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0,
                     32'hFFF0_0000, 32'h0020_0000);
        hold_req = hold_req + 1;
        run_paths(150);
        drain();

        send_idle_pct = 0; recv_stall_pct = 0;
        program_random();
        run_paths(300);
        drain();

        $display("%0d transactions sent (%0d path starts), %0d results checked, 6 register settings",
                 n_items, n_starts, sb.checked);
        if (sb.errors == 0 && sb.predicted_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
